// ===== hw/rtl/command_frame_receiver_top_assert.svh =====
// Assertion macros for the command frame receiver.
// Used by command_frame_receiver_top; no other dependencies.
`ifndef COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfr assertion failed");
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfr assertion failed");
`else
`define CFR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/cfr_pkg.sv =====
// Shared codes and constants for the command frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfr_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned ID_BYTES = 3;

  // Word opcodes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_BAD_START = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

  // Frame types
  localparam logic [1:0] FT_CMD  = 2'd0;
  localparam logic [1:0] FT_ACK  = 2'd1;
  localparam logic [1:0] FT_NACK = 2'd2;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_CMD_START  = 2'd0;
  localparam logic [1:0] REG_ACK_START  = 2'd1;
  localparam logic [1:0] REG_NACK_START = 2'd2;

  localparam logic [7:0] CMD_START_RST  = 8'd1;
  localparam logic [7:0] ACK_START_RST  = 8'd6;
  localparam logic [7:0] NACK_START_RST = 8'd21;

endpackage
`default_nettype wire

// ===== hw/rtl/command_frame_receiver_top.sv =====
// Command frame receiver; uses cfr_pkg and command_frame_receiver_top_assert.svh.
// An accepted word that gives a result has it on the output register in the next cycle.
// Throughput 1 word per cycle, sustained while the output side takes results
// (in_ready = output register empty or drained), set by the single-stage decode.
// Synchronous active-high reset returns to start hunting, clears held header fields,
// empties the output register and sets the start byte registers to 1, 6 and 21.
`timescale 1ns / 1ps
`default_nettype none
`include "command_frame_receiver_top_assert.svh"
module command_frame_receiver_top
  import cfr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // APB config port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // input words
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                opcode,
  input  wire logic [7:0]          rx_byte,
  // result words
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               result_kind,
  output logic [7:0]               payload_byte,
  output logic [7:0]               payload_index,
  output logic                     payload_last,
  output logic [1:0]               frame_type,
  output logic [7:0]               frame_address,
  output logic [23:0]              command_id,
  output logic [7:0]               payload_length,
  output logic [7:0]               header_check,
  output logic [7:0]               data_check
);

  // Frame parse stages. Code 7 is never entered and is treated as hunting.
  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_ADDR = 3'd1,
    ST_CMD  = 3'd2,
    ST_LEN  = 3'd3,
    ST_HCHK = 3'd4,
    ST_DATA = 3'd5,
    ST_DCHK = 3'd6
  } stage_t;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [7:0] cmd_start_value;
  logic [7:0] ack_start_value;
  logic [7:0] nack_start_value;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_start_value  <= CMD_START_RST;
      ack_start_value  <= ACK_START_RST;
      nack_start_value <= NACK_START_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_CMD_START:  cmd_start_value  <= pwdata[7:0];
        REG_ACK_START:  ack_start_value  <= pwdata[7:0];
        REG_NACK_START: nack_start_value <= pwdata[7:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CMD_START:  prdata = {24'd0, cmd_start_value};
      REG_ACK_START:  prdata = {24'd0, ack_start_value};
      REG_NACK_START: prdata = {24'd0, nack_start_value};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------
  stage_t      stage, stage_next;
  logic [1:0]  kind_held, kind_held_next;
  logic [7:0]  address_held, address_held_next;
  logic [23:0] command_held, command_held_next;
  logic [7:0]  length_held, length_held_next;
  logic [7:0]  header_check_held, header_check_held_next;
  logic [7:0]  byte_counter, byte_counter_next;

  logic        in_accept;
  logic [8:0]  count_inc;   // one wider so the last-byte compare can't wrap

  // result of the current word
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_pbyte;
  logic [7:0]  res_pindex;
  logic        res_plast;
  logic        res_hdr;     // completion word: header fields go out
  logic [7:0]  res_dchk;

  // Output register is the only buffer: a new word comes in whenever the
  // held result leaves in the same cycle or there is none.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign count_inc = {1'b0, byte_counter} + 9'd1;

  always_comb begin
    stage_next             = stage;
    kind_held_next         = kind_held;
    address_held_next      = address_held;
    command_held_next      = command_held;
    length_held_next       = length_held;
    header_check_held_next = header_check_held;
    byte_counter_next      = byte_counter;
    res_valid  = 1'b0;
    res_kind   = KIND_PAYLOAD;
    res_pbyte  = 8'd0;
    res_pindex = 8'd0;
    res_plast  = 1'b0;
    res_hdr    = 1'b0;
    res_dchk   = 8'd0;

    if (opcode == OP_TIMEOUT) begin
      // abort in any stage; held header values are simply left stale
      stage_next        = ST_HUNT;
      byte_counter_next = 8'd0;
      res_valid         = 1'b1;
      res_kind          = KIND_TIMEOUT;
    end else begin
      unique case (stage)
        ST_ADDR: begin
          address_held_next = rx_byte;
          command_held_next = 24'd0;
          byte_counter_next = 8'd0;
          stage_next        = ST_CMD;
        end
        ST_CMD: begin
          command_held_next = {command_held[15:0], rx_byte};
          byte_counter_next = count_inc[7:0];
          if (count_inc >= 9'(ID_BYTES)) begin
            byte_counter_next = 8'd0;
            stage_next        = ST_LEN;
          end
        end
        ST_LEN: begin
          length_held_next = rx_byte;
          stage_next       = ST_HCHK;
        end
        ST_HCHK: begin
          header_check_held_next = rx_byte;
          byte_counter_next      = 8'd0;
          if (length_held != 8'd0) begin
            stage_next = ST_DATA;
          end else begin
            // empty frame ends at the header check byte
            stage_next = ST_HUNT;
            res_valid  = 1'b1;
            res_kind   = KIND_COMPLETE;
            res_hdr    = 1'b1;
          end
        end
        ST_DATA: begin
          res_valid         = 1'b1;
          res_kind          = KIND_PAYLOAD;
          res_pbyte         = rx_byte;
          res_pindex        = byte_counter;
          res_plast         = (count_inc >= {1'b0, length_held});
          byte_counter_next = count_inc[7:0];
          if (res_plast) begin
            stage_next = ST_DCHK;
          end
        end
        ST_DCHK: begin
          stage_next        = ST_HUNT;
          byte_counter_next = 8'd0;
          res_valid         = 1'b1;
          res_kind          = KIND_COMPLETE;
          res_hdr           = 1'b1;
          res_dchk          = rx_byte;
        end
        default: begin
          // hunting: command wins over ack, ack over nack on equal values
          stage_next = ST_ADDR;
          priority if (rx_byte == cmd_start_value) begin
            kind_held_next = FT_CMD;
          end else if (rx_byte == ack_start_value) begin
            kind_held_next = FT_ACK;
          end else if (rx_byte == nack_start_value) begin
            kind_held_next = FT_NACK;
          end else begin
            stage_next = ST_HUNT;
            res_valid  = 1'b1;
            res_kind   = KIND_BAD_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage             <= ST_HUNT;
      kind_held         <= 2'd0;
      address_held      <= 8'd0;
      command_held      <= 24'd0;
      length_held       <= 8'd0;
      header_check_held <= 8'd0;
      byte_counter      <= 8'd0;
    end else if (in_accept) begin
      stage             <= stage_next;
      kind_held         <= kind_held_next;
      address_held      <= address_held_next;
      command_held      <= command_held_next;
      length_held       <= length_held_next;
      header_check_held <= header_check_held_next;
      byte_counter      <= byte_counter_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset; fields outside a word's kind are zero
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      result_kind    <= res_kind;
      payload_byte   <= res_pbyte;
      payload_index  <= res_pindex;
      payload_last   <= res_plast;
      frame_type     <= res_hdr ? kind_held         : 2'd0;
      frame_address  <= res_hdr ? address_held      : 8'd0;
      command_id     <= res_hdr ? command_held      : 24'd0;
      payload_length <= res_hdr ? length_held       : 8'd0;
      header_check   <= res_hdr ? header_check_held_next : 8'd0;
      data_check     <= res_dchk;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `CFR_ASSERT_NEXT(a_timeout_result, clk, rst, in_accept && opcode == OP_TIMEOUT,
    out_valid && result_kind == KIND_TIMEOUT && stage == ST_HUNT)
  `CFR_ASSERT_IMPL(a_last_then_dchk, clk, rst,
    out_valid && result_kind == KIND_PAYLOAD && payload_last, stage == ST_DCHK)
  `CFR_ASSERT_NEXT(a_hchk_exit, clk, rst,
    in_accept && opcode == OP_BYTE && stage == ST_HCHK,
    stage == ST_HUNT || stage == ST_DATA)

endmodule
`default_nettype wire

// ===== dv/tb_command_frame_receiver_top.sv =====
// Self-checking testbench for command_frame_receiver_top.
// Needs cfr_pkg and the receiver RTL; it drives words, APB writes and output stalls, and
// checks every result word against its own deframing predictor.
`timescale 1ns / 1ps
module tb_command_frame_receiver_top;
  import cfr_pkg::*;

  // Longest correct quiet stretch is the output hold-off plus a drain and three
  // APB write/read pairs, so reaching QUIET_LIMIT quiet cycles means the block hung.
  localparam int QUIET_LIMIT   = 2000;
  // Result comes in the cycle after its word; the settle wait covers words that
  // give no result but may still be in flight.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_WORDS   = 260;
  localparam int HOLD_CYCLES   = 150;
  localparam int PRED_DEPTH    = 16;
  localparam int MAX_FRAME     = 263;

  // Deframer stages as the predictor tracks them
  typedef enum logic [2:0] {
    S_HUNT, S_ADDR, S_CMD_ID, S_LENGTH, S_HDR_CHK, S_PAYLOAD, S_DATA_CHK
  } rx_stage_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic [7:0]  pindex;
    logic        plast;
    logic [1:0]  ftype;
    logic [7:0]  addr;
    logic [23:0] cmd_id;
    logic [7:0]  len;
    logic [7:0]  hchk;
    logic [7:0]  dchk;
  } rx_result_t;

  // DUT ports; every input has a known value from time zero
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OP_BYTE;
  logic [7:0]          rx_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          result_kind;
  logic [7:0]          payload_byte;
  logic [7:0]          payload_index;
  logic                payload_last;
  logic [1:0]          frame_type;
  logic [7:0]          frame_address;
  logic [23:0]         command_id;
  logic [7:0]          payload_length;
  logic [7:0]          header_check;
  logic [7:0]          data_check;

  command_frame_receiver_top dut (.*);

  // Predictor copy of the start byte registers and the frame state
  logic [7:0]  cmd_start  = CMD_START_RST;
  logic [7:0]  ack_start  = ACK_START_RST;
  logic [7:0]  nack_start = NACK_START_RST;
  rx_stage_t   stage_m    = S_HUNT;
  logic [1:0]  type_m     = FT_CMD;
  logic [7:0]  addr_m     = '0;
  logic [23:0] id_m       = '0;
  logic [7:0]  len_m      = '0;
  logic [7:0]  hchk_m     = '0;
  int          count_m    = 0;

  // expected result words, oldest first, in a small ring
  rx_result_t  predicted[PRED_DEPTH];
  int          pred_wr = 0;
  int          pred_rd = 0;

  int fail_count     = 0;
  int words_sent     = 0;
  int words_taken    = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 37;
  int recv_idle_pct  = 37;
  int hold_left      = 0;
  int kind_seen[4]   = '{0, 0, 0, 0};

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pending_count();
    return pred_wr - pred_rd;
  endfunction

  function automatic void pred_store(input rx_result_t r);
    if (pending_count() >= PRED_DEPTH) begin
      $error("prediction ring overflow");
      fail_count++;
    end
    predicted[pred_wr % PRED_DEPTH] = r;
    pred_wr++;
  endfunction

  // ------------------------------------------------------------------
  // Predictor: one accepted word in, zero or one expected result out
  // ------------------------------------------------------------------
  function automatic rx_result_t frame_done(input logic [7:0] dchk);
    rx_result_t r;
    r        = '0;
    r.kind   = KIND_COMPLETE;
    r.ftype  = type_m;
    r.addr   = addr_m;
    r.cmd_id = id_m;
    r.len    = len_m;
    r.hchk   = hchk_m;
    r.dchk   = dchk;
    return r;
  endfunction

  function automatic void deframe_predict(input logic op, input logic [7:0] b);
    rx_result_t r;
    r = '0;
    // timeout aborts from any stage; held header fields are simply left stale
    if (op == OP_TIMEOUT) begin
      stage_m = S_HUNT;
      count_m = 0;
      r.kind  = KIND_TIMEOUT;
      pred_store(r);
      return;
    end
    case (stage_m)
      S_ADDR: begin
        addr_m  = b;
        id_m    = '0;
        count_m = 0;
        stage_m = S_CMD_ID;
      end
      S_CMD_ID: begin
        id_m    = {id_m[15:0], b};   // first id byte ends up in bits 23:16
        count_m = count_m + 1;
        if (count_m >= ID_BYTES) begin
          count_m = 0;
          stage_m = S_LENGTH;
        end
      end
      S_LENGTH: begin
        len_m   = b;
        stage_m = S_HDR_CHK;
      end
      S_HDR_CHK: begin
        hchk_m  = b;
        count_m = 0;
        if (len_m != 0) begin
          stage_m = S_PAYLOAD;
        end else begin
          // header-only frame completes here with a zero data check
          stage_m = S_HUNT;
          pred_store(frame_done(8'h00));
        end
      end
      S_PAYLOAD: begin
        r.kind   = KIND_PAYLOAD;
        r.pbyte  = b;
        r.pindex = count_m[7:0];
        r.plast  = (count_m + 1 >= len_m);
        count_m  = count_m + 1;
        if (r.plast) stage_m = S_DATA_CHK;
        pred_store(r);
      end
      S_DATA_CHK: begin
        stage_m = S_HUNT;
        count_m = 0;
        pred_store(frame_done(b));
      end
      default: begin
        // hunting: command wins over ack, ack over nack when registers match
        if (b == cmd_start) begin
          type_m  = FT_CMD;
          stage_m = S_ADDR;
        end else if (b == ack_start) begin
          type_m  = FT_ACK;
          stage_m = S_ADDR;
        end else if (b == nack_start) begin
          type_m  = FT_NACK;
          stage_m = S_ADDR;
        end else begin
          r.kind = KIND_BAD_START;
          pred_store(r);
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Monitors: predict on every accepted word, check every accepted result
  // ------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      deframe_predict(opcode, rx_byte);
      words_taken++;
    end
  end

  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_count() == 0) begin
        $error("result word kind %0d arrived with nothing expected", result_kind);
        fail_count++;
      end else begin
        want = predicted[pred_rd % PRED_DEPTH];
        pred_rd++;
        kind_seen[want.kind]++;
        check_field("result_kind",    24'(want.kind),   24'(result_kind));
        check_field("payload_byte",   24'(want.pbyte),  24'(payload_byte));
        check_field("payload_index",  24'(want.pindex), 24'(payload_index));
        check_field("payload_last",   24'(want.plast),  24'(payload_last));
        check_field("frame_type",     24'(want.ftype),  24'(frame_type));
        check_field("frame_address",  24'(want.addr),   24'(frame_address));
        check_field("command_id",     want.cmd_id,      command_id);
        check_field("payload_length", 24'(want.len),    24'(payload_length));
        check_field("header_check",   24'(want.hchk),   24'(header_check));
        check_field("data_check",     24'(want.dchk),   24'(data_check));
      end
    end
  end

  // Result side: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_count());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  // Offer one word; returns at the edge where it is taken.
  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    rx_byte  <= b;
    words_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sends start, address, id, length, header check, then payload and data check if len is nonzero.
  // abort_at >= 0 replaces the byte at that position with a timeout word.
  task automatic send_frame(input logic [7:0] start, input logic [7:0] addr,
                            input logic [23:0] id, input logic [7:0] len,
                            input int abort_at);
    logic [7:0] seq[MAX_FRAME];
    int n;
    int i;
    seq[0] = start;
    seq[1] = addr;
    seq[2] = id[23:16];
    seq[3] = id[15:8];
    seq[4] = id[7:0];
    seq[5] = len;
    seq[6] = 8'($urandom_range(0, 255));
    n = 7;
    for (i = 0; i < len; i++) begin
      seq[n] = 8'($urandom_range(0, 255));
      n++;
    end
    if (len != 0) begin
      seq[n] = 8'($urandom_range(0, 255));
      n++;
    end
    for (i = 0; i < n; i++) begin
      if (i == abort_at) begin
        send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        return;
      end
      send_word(OP_BYTE, seq[i]);
    end
  endtask

  // Sender goes quiet until every expected result is back, then lets any
  // result-less word finish its cycle in the block.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register
  task automatic apb_write(input logic [1:0] reg_idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      REG_CMD_START:  cmd_start  = value;
      REG_ACK_START:  ack_start  = value;
      REG_NACK_START: nack_start = value;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", 24'(value), 24'(prdata[7:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_start_bytes(input logic [7:0] c, input logic [7:0] a,
                                  input logic [7:0] n);
    wait_drain();
    apb_write(REG_CMD_START, c);
    apb_write(REG_ACK_START, a);
    apb_write(REG_NACK_START, n);
    settings_used++;
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Reset start bytes: timeouts, bad starts at both byte extremes, a header-only
  // command frame with all-ones address and id, a one-byte ack frame with all-zero
  // address and id, and a nack frame cut short inside its command id.
  task automatic test_directed_basics();
    send_word(OP_TIMEOUT, 8'h00);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_frame(cmd_start, 8'hFF, 24'hFFFFFF, 8'd0, -1);
    send_frame(ack_start, 8'h00, 24'h000000, 8'd1, -1);
    send_frame(nack_start, 8'h5A, 24'h123456, 8'd2, 2);
    send_word(OP_TIMEOUT, 8'hFF);
    wait_drain();
  endtask

  // Equal start registers resolve command first, then ack; register extremes.
  task automatic test_start_priority();
    load_start_bytes(8'h00, 8'h00, 8'h00);
    send_frame(8'h00, 8'h81, 24'h800001, 8'd0, -1);
    load_start_bytes(8'hFF, 8'h80, 8'h80);
    send_frame(8'h80, 8'h7E, 24'h7F00FE, 8'd0, -1);
    load_start_bytes(8'h00, 8'h01, 8'hFF);
    send_frame(8'hFF, 8'h3C, 24'hA5A5A5, 8'd0, -1);
    wait_drain();
  endtask

  // Mostly whole frames with random content; some cut off by a timeout at a
  // random point, some stray bytes, some lone timeouts. One phase per setting.
  task automatic test_random_traffic();
    int phase_end;
    int r;
    int len;
    int fsize;
    logic [7:0] start;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_start_bytes(CMD_START_RST, ACK_START_RST, NACK_START_RST);
        1: load_start_bytes(8'h00, 8'hFF, 8'h80);
        2: load_start_bytes(8'hFF, 8'h00, 8'h01);
        default: load_start_bytes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
      endcase
      // one phase runs flat out on both sides
      send_idle_pct = (p == 4) ? 0 : 37;
      recv_idle_pct = (p == 4) ? 0 : 37;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 84) begin
          r = $urandom_range(0, 99);
          if (r < 30)      len = 0;
          else if (r < 89) len = $urandom_range(1, 8);
          else if (r < 99) len = $urandom_range(9, 40);
          else             len = 255;
          case ($urandom_range(0, 2))
            0:       start = cmd_start;
            1:       start = ack_start;
            default: start = nack_start;
          endcase
          fsize = 7 + len + ((len != 0) ? 1 : 0);
          send_frame(start, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                     8'(len),
                     ($urandom_range(0, 99) < 14) ? int'($urandom_range(0, fsize - 1)) : -1);
        end else if (r < 93) begin
          send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        end else begin
          send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end
      end
    end
    send_idle_pct = 37;
    recv_idle_pct = 37;
    wait_drain();
  endtask

  // Result side holds off while a maximum-length frame streams in without gaps,
  // so the block fills and stalls its input; then the sender waits it out.
  task automatic test_output_backpressure();
    load_start_bytes(CMD_START_RST, ACK_START_RST, NACK_START_RST);
    send_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    send_frame(ack_start, 8'hC3, 24'h00FF00, 8'd255, -1);
    send_idle_pct = 37;
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basics();
    test_start_priority();
    test_random_traffic();
    test_output_backpressure();

    wait_drain();
    if (pending_count() != 0) begin
      $error("%0d expected results never arrived", pending_count());
      fail_count++;
    end
    $display("run: %0d words in, %0d start-byte settings, %0d mismatches",
             words_taken, settings_used, fail_count);
    $display("results: %0d payload, %0d complete, %0d bad start, %0d timeout",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_COMPLETE],
             kind_seen[KIND_BAD_START], kind_seen[KIND_TIMEOUT]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
